// ----- rtl/core/newline_row_indexer_core_defines.svh -----
// assertion macros for the newline row indexer
`ifndef NEWLINE_ROW_INDEXER_CORE_DEFINES_SVH
`define NEWLINE_ROW_INDEXER_CORE_DEFINES_SVH

// assert that a condition implies another at the same edge
`define NRI_ASSERT_IMP(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("assertion failed");

// assert that a condition implies another at the next edge
`define NRI_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/nri_pkg.sv -----
// shared constants and types of the newline row indexer
package nri_pkg;
	localparam int AnchorDepthDef = 32;
	localparam int OffsetBitsDef = 40;
	localparam int RowBitsDef = 32;
	localparam int ByteBits = 41;

	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_END = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FILE_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_TOO_MANY_ROWS = 2'd2;
	localparam logic [1:0] ST_LINE_TOO_LONG = 2'd3;

	localparam logic [2:0] REG_MAX_ROWS = 3'd0;
	localparam logic [2:0] REG_MAX_LINE = 3'd1;
	localparam logic [2:0] REG_MAX_FILE = 3'd2;
	localparam logic [2:0] REG_PAGE = 3'd3;
	localparam logic [2:0] REG_CURSORS = 3'd4;

	localparam logic [7:0] NEWLINE = 8'd10;
	localparam int MinCapacity = 2;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_NL     = 7'b0000010,
		S_DIVC   = 7'b0000100,
		S_CRD    = 7'b0001000,
		S_CCHK   = 7'b0010000,
		S_ADD    = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;
endpackage

// ----- rtl/core/newline_row_indexer_core.sv -----
// newline row indexer top level: byte scan, anchor table and readback
//
// channel  | beat signals                         | payload
// in       | in_valid / in_ready                  | command, data_byte, anchor_index
// out      | out_valid / out_ready                | result_kind .. anchor_offset
// cfg      | psel, penable, pwrite, pready        | paddr, pwdata, prdata
//
// a plain byte passes S_NL to idle; a counted newline then waits in S_CCHK for the remainder unit,
// with a further check there when the new row is a stride multiple and the table has room
// readback and end pass S_NL and S_OUT
// a full table adds a compaction walk of S_ADD, S_CRD, S_DIVC, S_CCHK per entry and a final check
// the remainder unit is a shift-subtract divider, one quotient bit per cycle
// arst_n clears all control state; the table needs no clear (entry 0 reads back as zero)
// in_ready drops while an item is in work; a result holds in S_OUT while the output reg is full
`include "newline_row_indexer_core_defines.svh"
module newline_row_indexer_core #(
	parameter int ANCHOR_DEPTH = nri_pkg::AnchorDepthDef,
	parameter int OFFSET_BITS = nri_pkg::OffsetBitsDef,
	parameter int ROW_BITS = nri_pkg::RowBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic [4:0]  anchor_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [1:0]  status,
	output logic [31:0] row_count,
	output logic [5:0]  anchor_count,
	output logic [31:0] anchor_row,
	output logic [39:0] anchor_offset
);
	import nri_pkg::*;

	localparam int AW = (ANCHOR_DEPTH > 1) ? $clog2(ANCHOR_DEPTH) : 1;
	localparam int CW = $clog2(ANCHOR_DEPTH + 1);
	localparam int DW = $clog2(ROW_BITS + 1);
	localparam logic [ROW_BITS-1:0] RowMax = '1;
	localparam logic [OFFSET_BITS-1:0] OffMax = '1;
	localparam logic [1:0] DIV_ROW = 2'd0;
	localparam logic [1:0] DIV_COMP = 2'd1;
	localparam logic [1:0] DIV_POST = 2'd2;

	logic [31:0] max_rows_q;
	logic [15:0] max_line_q;
	logic [39:0] max_file_q;
	logic [15:0] page_q;
	logic [6:0]  cursors_q;

	logic [ROW_BITS-1:0] rows_q, stride_q;
	logic [16:0] line_q;
	logic [ByteBits-1:0] boff_q;
	logic [CW-1:0] valid_q;
	logic [1:0] err_q;
	logic saw_q;

	state_t state_q;
	logic [1:0] cmd_q;
	logic [7:0] byte_q;
	logic [4:0] idx_q;

	// anchor memory, one entry of row and offset
	logic [ROW_BITS+OFFSET_BITS-1:0] mem [ANCHOR_DEPTH];
	logic [ROW_BITS+OFFSET_BITS-1:0] rd_s1;
	logic [AW-1:0] raddr, waddr;
	logic we;
	logic [ROW_BITS+OFFSET_BITS-1:0] wdata;

	// remainder unit
	logic [ROW_BITS-1:0] dnum_q, drem_q;
	logic [DW-1:0] dcnt_q;
	logic dbusy_q;
	logic [ROW_BITS:0] dtry;
	logic dstart;
	logic [ROW_BITS-1:0] dstart_num;
	logic dzero;
	logic [1:0] dpurpose_q; // 0 new row check, 1 compact check, 2 append check after a new row or a compaction

	logic [CW-1:0] rd_q, wr_q;
	logic [ROW_BITS+OFFSET_BITS-1:0] cent_q;

	logic [CW-1:0] cap;
	logic [6:0] half;

	logic cfg_wr;
	logic [1:0] cur_status;
	logic row_limit_hit;
	logic nl_go;

	logic out_v_q;
	logic out_kind_q;
	logic [1:0] out_st_q;
	logic [31:0] out_rows_q;
	logic [5:0] out_cnt_q;
	logic [31:0] out_arow_q;
	logic [39:0] out_aoff_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[5:3])
			REG_MAX_ROWS: prdata = {32'd0, max_rows_q};
			REG_MAX_LINE: prdata = {48'd0, max_line_q};
			REG_MAX_FILE: prdata = {24'd0, max_file_q};
			REG_PAGE:     prdata = {48'd0, page_q};
			REG_CURSORS:  prdata = {57'd0, cursors_q};
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		half = {1'b0, cursors_q[6:1]};
		if (half < 7'(MinCapacity)) cap = CW'(MinCapacity);
		else if (32'(half) > 32'(ANCHOR_DEPTH)) cap = CW'(ANCHOR_DEPTH);
		else cap = CW'(half);
	end

	assign cur_status = ({23'd0, boff_q} > {24'd0, max_file_q}) ? ST_FILE_TOO_LARGE : err_q;
	assign row_limit_hit = {{(32){1'b0}}, rows_q} >= {{(ROW_BITS){1'b0}}, max_rows_q};
	assign nl_go = (err_q == ST_OK) && (byte_q == NEWLINE) && !row_limit_hit;

	assign in_ready = (state_q == S_IDLE);
	assign dtry = {drem_q, dnum_q[ROW_BITS-1]} - {1'b0, stride_q};
	assign dzero = (drem_q == '0);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_s1 <= mem[raddr];
	end

	logic [ROW_BITS-1:0] rows_next;
	logic [ROW_BITS-1:0] stride_dbl;
	assign rows_next = rows_q + 1'b1;
	assign stride_dbl = (stride_q > (RowMax >> 1)) ? RowMax : (stride_q << 1);

	always_comb begin
		raddr = AW'(idx_q);
		we = 1'b0;
		waddr = AW'(valid_q);
		wdata = {rows_q, (boff_q > ByteBits'(OffMax)) ? OffMax : OFFSET_BITS'(boff_q)};
		dstart = 1'b0;
		dstart_num = rows_q;
		case (state_q)
			S_DIVC: raddr = AW'(rd_q);
			S_CRD:  raddr = AW'(rd_q);
			S_CCHK: begin
				if (!dbusy_q && dpurpose_q == DIV_COMP && dzero) begin
					we = 1'b1;
					waddr = AW'(wr_q);
					wdata = cent_q;
				end
				if (!dbusy_q && dpurpose_q == DIV_POST && dzero && valid_q < cap) we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rows_q <= 32'd65535;
			max_line_q <= 16'd4096;
			max_file_q <= 40'd16777216;
			page_q <= 16'd10;
			cursors_q <= 7'd32;
			rows_q <= '0;
			stride_q <= ROW_BITS'(10);
			line_q <= '0;
			boff_q <= '0;
			valid_q <= CW'(1);
			err_q <= ST_OK;
			saw_q <= 1'b0;
			state_q <= S_IDLE;
			cmd_q <= CMD_BYTE;
			byte_q <= '0;
			idx_q <= '0;
			dnum_q <= '0;
			drem_q <= '0;
			dcnt_q <= '0;
			dbusy_q <= 1'b0;
			dpurpose_q <= DIV_ROW;
			rd_q <= '0;
			wr_q <= '0;
			cent_q <= '0;
			out_v_q <= 1'b0;
			out_kind_q <= 1'b0;
			out_st_q <= ST_OK;
			out_rows_q <= '0;
			out_cnt_q <= '0;
			out_arow_q <= '0;
			out_aoff_q <= '0;
		end else begin
			if (out_v_q && out_ready && state_q != S_OUT) out_v_q <= 1'b0;
			if (cfg_wr) begin
				case (paddr[5:3])
					REG_MAX_ROWS: max_rows_q <= pwdata[31:0];
					REG_MAX_LINE: max_line_q <= pwdata[15:0];
					REG_MAX_FILE: max_file_q <= pwdata[39:0];
					REG_PAGE: begin
						page_q <= pwdata[15:0];
						if (rows_q == '0)
							stride_q <= (pwdata[15:0] == 16'd0) ? ROW_BITS'(1)
								: ROW_BITS'(pwdata[15:0]);
					end
					REG_CURSORS: cursors_q <= pwdata[6:0];
					default: ;
				endcase
			end
			// remainder iteration, one bit per cycle
			if (dbusy_q) begin
				if (!dtry[ROW_BITS]) drem_q <= dtry[ROW_BITS-1:0];
				else drem_q <= {drem_q[ROW_BITS-2:0], dnum_q[ROW_BITS-1]};
				dnum_q <= dnum_q << 1;
				dcnt_q <= dcnt_q - 1'b1;
				if (dcnt_q == DW'(1)) dbusy_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= command;
						byte_q <= data_byte;
						idx_q <= anchor_index;
						state_q <= S_NL;
					end
				end
				S_NL: begin
					case (cmd_q)
						CMD_BYTE: begin
							state_q <= nl_go ? S_CCHK : S_IDLE;
							saw_q <= 1'b1;
							if (boff_q != '1) boff_q <= boff_q + 1'b1;
							if (err_q == ST_OK) begin
								if (byte_q == NEWLINE) begin
									if (row_limit_hit) err_q <= ST_TOO_MANY_ROWS;
									else begin
										rows_q <= rows_next;
										line_q <= '0;
										dnum_q <= rows_next;
										drem_q <= '0;
										dcnt_q <= DW'(ROW_BITS);
										dbusy_q <= 1'b1;
										dpurpose_q <= DIV_ROW;
									end
								end else if (line_q >= {1'b0, max_line_q})
									err_q <= ST_LINE_TOO_LONG;
								else line_q <= line_q + 1'b1;
							end
						end
						CMD_END, CMD_READ: begin
							state_q <= S_OUT;
							if (cmd_q == CMD_END) begin
								if (err_q == ST_OK && saw_q && line_q != '0) begin
									if (row_limit_hit) err_q <= ST_TOO_MANY_ROWS;
									else rows_q <= rows_next;
								end
								line_q <= '0;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_CRD: begin
					// read data arrives next cycle
					state_q <= S_DIVC;
				end
				S_DIVC: begin
					cent_q <= rd_s1;
					dnum_q <= rd_s1[ROW_BITS+OFFSET_BITS-1:OFFSET_BITS];
					drem_q <= '0;
					dcnt_q <= DW'(ROW_BITS);
					dbusy_q <= 1'b1;
					dpurpose_q <= DIV_COMP;
					state_q <= S_CCHK;
				end
				S_CCHK: begin
					if (!dbusy_q) begin
						case (dpurpose_q)
							DIV_ROW: begin
								if (!dzero) state_q <= S_IDLE;
								else if (valid_q >= cap) begin
									stride_q <= stride_dbl;
									rd_q <= CW'(1);
									wr_q <= CW'(1);
									state_q <= S_ADD;
								end else begin
									dpurpose_q <= DIV_POST;
								end
							end
							DIV_COMP: begin
								if (dzero) wr_q <= wr_q + 1'b1;
								rd_q <= rd_q + 1'b1;
								state_q <= S_ADD;
							end
							default: begin
								if (dzero && valid_q < cap) valid_q <= valid_q + 1'b1;
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ADD: begin
					// compaction loop head
					if (rd_q < valid_q && 32'(rd_q) < 32'(ANCHOR_DEPTH)) state_q <= S_CRD;
					else begin
						valid_q <= wr_q;
						dnum_q <= rows_q;
						drem_q <= '0;
						dcnt_q <= DW'(ROW_BITS);
						dbusy_q <= 1'b1;
						dpurpose_q <= DIV_POST;
						state_q <= S_CCHK;
					end
				end
				S_OUT: begin
					// hold the result until the output register is free
					if (!out_v_q || out_ready) begin
						out_v_q <= 1'b1;
						out_kind_q <= (cmd_q == CMD_READ);
						out_st_q <= cur_status;
						out_rows_q <= 32'(rows_q);
						out_cnt_q <= 6'(valid_q);
						if (cmd_q == CMD_READ && {27'd0, idx_q} < 32'(valid_q)
							&& idx_q != '0) begin
							out_arow_q <= 32'(rd_s1[ROW_BITS+OFFSET_BITS-1:OFFSET_BITS]);
							out_aoff_q <= 40'(rd_s1[OFFSET_BITS-1:0]);
						end else begin
							out_arow_q <= '0;
							out_aoff_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_v_q;
	assign result_kind = out_kind_q;
	assign status = out_st_q;
	assign row_count = out_rows_q;
	assign anchor_count = out_cnt_q;
	assign anchor_row = out_arow_q;
	assign anchor_offset = out_aoff_q;

	`NRI_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !in_ready)
	`NRI_ASSERT_IMP(a_valid_cap, clk, arst_n, 1'b1, valid_q <= cap || valid_q <= CW'(ANCHOR_DEPTH))
	`NRI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_v_q && !out_ready, out_v_q)
	`NRI_ASSERT_IMP(a_valid_nonzero, clk, arst_n, 1'b1, valid_q != '0)
endmodule

// ----- tb/sv/tb.sv -----
// testbench for the newline row indexer: byte scan, anchor table, status and readback
`timescale 1ns / 1ps
module tb;
	import nri_pkg::*;

	localparam longint unsigned CYCLE_LIMIT = 64'd3000000;
	localparam int DRAIN_CYCLES = 1500;
	localparam longint unsigned OFF_MAX = 64'hFF_FFFF_FFFF;
	localparam longint unsigned BYTE_MAX = (64'd1 << 41) - 1;
	localparam longint unsigned ROW_MAX = 64'hFFFF_FFFF;
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef struct {
		logic            kind;
		logic [1:0]      stat;
		logic [31:0]     rows;
		logic [5:0]      cnt;
		logic [31:0]     arow;
		logic [39:0]     aoff;
	} scan_result_t;

	typedef struct {
		logic [1:0]   cmd;
		logic [7:0]   data;
		logic [4:0]   idx;
		bit           fixed;
		scan_result_t res;
	} dir_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] command = CMD_BYTE;
	logic [7:0] data_byte = '0;
	logic [4:0] anchor_index = '0;
	logic out_valid;
	logic out_ready = 0;
	logic result_kind;
	logic [1:0] status;
	logic [31:0] row_count;
	logic [5:0] anchor_count;
	logic [31:0] anchor_row;
	logic [39:0] anchor_offset;

	newline_row_indexer_core uut (.*);

	always #4 clk = ~clk;

	// scan model state
	longint unsigned row_limit, line_limit, size_limit, page_rows, cursor_budget;
	longint unsigned rows_done, line_len, bytes_in, stride;
	longint unsigned anc_row [32];
	longint unsigned anc_off [32];
	int unsigned anc_cnt;
	logic [1:0] sticky_err;
	bit any_byte;

	scan_result_t pending_results[$];
	int errors = 0;
	int checked = 0;
	int items_sent = 0;
	longint unsigned cycles = 0;
	int stall_left = 0;
	bit sink_calm = 0;

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	function automatic int unsigned table_cap();
		longint unsigned c;
		c = cursor_budget / 2;
		if (c < MinCapacity) c = MinCapacity;
		if (c > 32) c = 32;
		return int'(c);
	endfunction

	function automatic logic [1:0] live_status();
		if (bytes_in > size_limit) return ST_FILE_TOO_LARGE;
		return sticky_err;
	endfunction

	task automatic drop_off_stride();
		int unsigned w;
		w = 1;
		for (int unsigned r = 1; r < anc_cnt; r++) begin
			if (anc_row[r] % stride == 0) begin
				anc_row[w] = anc_row[r];
				anc_off[w] = anc_off[r];
				w++;
			end
		end
		anc_cnt = w;
	endtask

	task automatic take_newline();
		if (rows_done >= row_limit) begin
			sticky_err = ST_TOO_MANY_ROWS;
			return;
		end
		rows_done++;
		line_len = 0;
		if (rows_done % stride != 0) return;
		if (anc_cnt >= table_cap()) begin
			stride = (stride > ROW_MAX / 2) ? ROW_MAX : stride * 2;
			drop_off_stride();
		end
		if (rows_done % stride == 0 && anc_cnt < table_cap()) begin
			anc_row[anc_cnt] = rows_done;
			anc_off[anc_cnt] = bytes_in > OFF_MAX ? OFF_MAX : bytes_in;
			anc_cnt++;
		end
	endtask

	task automatic scan_item(logic [1:0] cmd, logic [7:0] b, logic [4:0] idx,
		output bit has_res, output scan_result_t res);
		has_res = 0;
		res = '{default: '0};
		if (cmd == CMD_BYTE) begin
			any_byte = 1;
			if (bytes_in < BYTE_MAX) bytes_in++;
			if (sticky_err != ST_OK) return;
			if (b == NEWLINE) take_newline();
			else if (line_len >= line_limit) sticky_err = ST_LINE_TOO_LONG;
			else line_len++;
			return;
		end
		if (cmd == CMD_NONE) return;
		if (cmd == CMD_END) begin
			if (sticky_err == ST_OK && any_byte && line_len > 0) begin
				if (rows_done >= row_limit) sticky_err = ST_TOO_MANY_ROWS;
				else rows_done++;
			end
			line_len = 0;
		end
		has_res = 1;
		res.kind = (cmd == CMD_READ);
		res.stat = live_status();
		res.rows = rows_done[31:0];
		res.cnt = anc_cnt[5:0];
		if (cmd == CMD_READ && idx < anc_cnt) begin
			res.arow = anc_row[idx][31:0];
			res.aoff = anc_off[idx][39:0];
		end
	endtask

	// register write: setup then access beat, then a look at the read data
	task automatic write_reg(logic [2:0] idx, longint unsigned value);
		longint unsigned kept;
		case (idx)
			REG_MAX_ROWS: kept = value & 64'hFFFF_FFFF;
			REG_MAX_LINE: kept = value & 64'hFFFF;
			REG_MAX_FILE: kept = value & OFF_MAX;
			REG_PAGE:     kept = value & 64'hFFFF;
			REG_CURSORS:  kept = value & 64'h7F;
			default:      kept = 0;
		endcase
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_MAX_ROWS: row_limit = kept;
			REG_MAX_LINE: line_limit = kept;
			REG_MAX_FILE: size_limit = kept;
			REG_PAGE: begin
				page_rows = kept;
				if (rows_done == 0) stride = (page_rows == 0) ? 1 : page_rows;
			end
			REG_CURSORS: cursor_budget = kept;
			default: ;
		endcase
		@(posedge clk);
		if (prdata !== kept) report("prdata", prdata, kept);
	endtask

	function automatic int pick_gap();
		if ($urandom_range(99) < 88) return $urandom_range(3, 1);
		return $urandom_range(60, 15);
	endfunction

	task automatic send(logic [1:0] cmd, logic [7:0] b, logic [4:0] idx, bit gaps,
		bit fixed, scan_result_t want);
		int gap;
		bit has_res;
		scan_result_t res;
		scan_result_t pick;
		gap = (gaps && $urandom_range(99) < 30) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		data_byte <= b;
		anchor_index <= idx;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		scan_item(cmd, b, idx, has_res, res);
		if (has_res) begin
			pick = fixed ? want : res;
			pending_results = {pending_results, pick};
		end
	endtask

	task automatic settle();
		in_valid <= 0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// random traffic: mostly short well-formed lines, with reads, ends and noise
	task automatic random_lines(int count, int max_len);
		int sent;
		int len;
		logic [7:0] b;
		scan_result_t none;
		none = '{default: '0};
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(99)) inside
				[0:9]: send(CMD_READ, 8'($urandom), 5'($urandom), 1, 0, none);
				[10:12]: send(CMD_END, 8'($urandom), 5'($urandom), 1, 0, none);
				13: send(CMD_NONE, 8'($urandom), 5'($urandom), 1, 0, none);
				default: begin
					len = $urandom_range(max_len);
					for (int i = 0; i < len; i++) begin
						do b = 8'($urandom); while (b == NEWLINE);
						send(CMD_BYTE, b, 5'($urandom), 1, 0, none);
					end
					sent += len;
					send(CMD_BYTE, NEWLINE, 5'($urandom), 1, 0, none);
				end
			endcase
			sent++;
		end
	endtask

	// result sink with random back-pressure
	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("unexpected result beat kind %0d", result_kind);
				errors++;
			end else begin
				want = pending_results.pop_front();
				checked++;
				if (result_kind !== want.kind) report("result_kind", result_kind, want.kind);
				if (status !== want.stat) report("status", status, want.stat);
				if (row_count !== want.rows) report("row_count", row_count, want.rows);
				if (anchor_count !== want.cnt) report("anchor_count", anchor_count, want.cnt);
				if (anchor_row !== want.arow) report("anchor_row", anchor_row, want.arow);
				if (anchor_offset !== want.aoff)
					report("anchor_offset", anchor_offset, want.aoff);
			end
		end
		if (stall_left > 0) begin
			out_ready <= 0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1;
			if (!sink_calm && $urandom_range(99) < 25) stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb: errors");
			$finish;
		end
	end

	dir_row_t dir_rows [12];

	initial begin
		scan_result_t none;
		none = '{default: '0};
		row_limit = 65535;
		line_limit = 4096;
		size_limit = 16777216;
		page_rows = 10;
		cursor_budget = 32;
		rows_done = 0;
		line_len = 0;
		bytes_in = 0;
		stride = 10;
		foreach (anc_row[i]) begin
			anc_row[i] = 0;
			anc_off[i] = 0;
		end
		anc_cnt = 1;
		sticky_err = ST_OK;
		any_byte = 0;

		dir_rows[0] = '{CMD_READ, 8'h00, 5'd0, 1, '{1'b1, ST_OK, 32'd0, 6'd1, 32'd0, 40'd0}};
		dir_rows[1] = '{CMD_READ, 8'hFF, 5'd31, 1, '{1'b1, ST_OK, 32'd0, 6'd1, 32'd0, 40'd0}};
		dir_rows[2] = '{CMD_END, 8'h00, 5'd0, 1, '{1'b0, ST_OK, 32'd0, 6'd1, 32'd0, 40'd0}};
		dir_rows[3] = '{CMD_NONE, 8'hFF, 5'd31, 0, none};
		dir_rows[4] = '{CMD_BYTE, 8'hFF, 5'd0, 0, none};
		dir_rows[5] = '{CMD_BYTE, 8'h00, 5'd0, 0, none};
		dir_rows[6] = '{CMD_BYTE, NEWLINE, 5'd0, 0, none};
		dir_rows[7] = '{CMD_BYTE, NEWLINE, 5'd0, 0, none};
		dir_rows[8] = '{CMD_BYTE, 8'h41, 5'd0, 0, none};
		dir_rows[9] = '{CMD_END, 8'h00, 5'd0, 0, none};
		dir_rows[10] = '{CMD_END, 8'h00, 5'd0, 0, none};
		dir_rows[11] = '{CMD_READ, 8'h00, 5'd1, 0, none};

		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// stride reload while no row is counted, smallest table
		write_reg(REG_PAGE, 1);
		write_reg(REG_CURSORS, 2);
		sink_calm = 1;
		foreach (dir_rows[i])
			send(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].idx, 0,
				dir_rows[i].fixed, dir_rows[i].res);
		settle();
		sink_calm = 0;

		write_reg(REG_CURSORS, 64);
		write_reg(REG_MAX_ROWS, ROW_MAX);
		write_reg(REG_MAX_LINE, 65535);
		write_reg(REG_MAX_FILE, OFF_MAX);
		write_reg(REG_PAGE, 3);
		random_lines(320, 4);
		settle();

		write_reg(REG_CURSORS, 5);
		write_reg(REG_PAGE, 65535);
		random_lines(200, 3);
		settle();

		// size limit exceeded, then lifted again
		write_reg(REG_CURSORS, 7);
		write_reg(REG_MAX_FILE, 1);
		sink_calm = 1;
		random_lines(150, 5);
		settle();
		sink_calm = 0;

		write_reg(REG_MAX_FILE, 16777216);
		write_reg(REG_CURSORS, 20);
		random_lines(250, 6);
		settle();

		// provoke one sticky error
		if ($urandom_range(1)) write_reg(REG_MAX_ROWS, rows_done + 3);
		else write_reg(REG_MAX_LINE, 2);
		random_lines(200, 5);
		settle();

		if (pending_results.size() != 0) begin
			$display("%0d results never arrived", pending_results.size());
			errors++;
		end
		$display("covered %0d items, %0d results checked, %0d rows, %0d anchors held",
			items_sent, checked, rows_done, anc_cnt);
		$display("final status %0d, %0d mismatches", live_status(), errors);
		if (errors == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end
endmodule
